// ===== rtl/core/rbv_pkg.sv =====
package rbv_pkg;

	typedef enum logic [1:0] {
		CODE_GENERAL  = 2'd0,
		CODE_IDENTITY = 2'd1,
		CODE_OPPOSITE = 2'd2
	} case_code_t;

	localparam int EPS_W = 15;
	localparam logic [EPS_W-1:0] EPS_RESET = 15'd16;

	// the largest normalized magnitude sits in [2^30, 2^31)
	localparam int NORM_W = 31;

	localparam int ROOT_W = 64;
	localparam int ROOT_STAGES = ROOT_W / 2;
	localparam int LEN_W = ROOT_W / 2;

	localparam int QUEUE_DEPTH = 4;

endpackage

// ===== rtl/core/rotation_between_vectors_unit.sv =====
// Shortest-arc quaternion from two fixed-point vectors.
// Throughput one request per cycle while no output stall holds the pipeline,
// set by the fully pipelined root and divider stages (one bit per stage).
// A 4-entry queue between classify and compute stages absorbs output stalls.
// Reset (arst_n low, asynchronous) empties every stage and sets epsilon to 16.
module rotation_between_vectors_unit #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                epsilon_we,
	input  logic [rbv_pkg::EPS_W-1:0]           epsilon_wdata,
	input  logic                                push,
	output logic                                full,
	input  logic signed [DATA_WIDTH-1:0]        from_x,
	input  logic signed [DATA_WIDTH-1:0]        from_y,
	input  logic signed [DATA_WIDTH-1:0]        from_z,
	input  logic signed [DATA_WIDTH-1:0]        to_x,
	input  logic signed [DATA_WIDTH-1:0]        to_y,
	input  logic signed [DATA_WIDTH-1:0]        to_z,
	input  logic                                pop,
	output logic                                empty,
	output logic signed [DATA_WIDTH-1:0]        quat_w,
	output logic signed [DATA_WIDTH-1:0]        quat_x,
	output logic signed [DATA_WIDTH-1:0]        quat_y,
	output logic signed [DATA_WIDTH-1:0]        quat_z,
	output logic [1:0]                          case_code
);

	localparam int AW = 2 * DATA_WIDTH + 1;
	localparam int VW = FRAC_BITS + 2;
	localparam int QDW = 2 + 3 * AW + 2 * VW;

	logic [rbv_pkg::EPS_W-1:0] eps_q;

	logic                 f_wr;
	rbv_pkg::case_code_t  f_code;
	logic signed [AW-1:0] f_ax, f_ay, f_az;
	logic [VW-1:0]        f_vw, f_vs;

	logic                 q_full, q_empty, q_rd;
	logic [QDW-1:0]       q_wdata, q_rdata;

	rbv_pkg::case_code_t  b_code_in;
	rbv_pkg::case_code_t  b_code_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= rbv_pkg::EPS_RESET;
		end else if (epsilon_we) begin
			eps_q <= epsilon_wdata;
		end
	end

	rbv_front #(
		.DW(DATA_WIDTH),
		.FB(FRAC_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.from_x(from_x),
		.from_y(from_y),
		.from_z(from_z),
		.to_x  (to_x),
		.to_y  (to_y),
		.to_z  (to_z),
		.eps   (eps_q),
		.q_full(q_full),
		.wr    (f_wr),
		.code  (f_code),
		.axis_x(f_ax),
		.axis_y(f_ay),
		.axis_z(f_az),
		.vw    (f_vw),
		.vs    (f_vs)
	);

	assign q_wdata = {f_code, f_ax, f_ay, f_az, f_vw, f_vs};

	rbv_queue #(
		.WIDTH(QDW),
		.DEPTH(rbv_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (f_wr),
		.wdata (q_wdata),
		.rd    (q_rd),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	assign b_code_in = rbv_pkg::case_code_t'(q_rdata[QDW-1 -: 2]);

	rbv_back #(
		.DW(DATA_WIDTH),
		.FB(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_rd     (q_rd),
		.code     (b_code_in),
		.axis_x   ($signed(q_rdata[2*VW+3*AW-1 -: AW])),
		.axis_y   ($signed(q_rdata[2*VW+2*AW-1 -: AW])),
		.axis_z   ($signed(q_rdata[2*VW+AW-1 -: AW])),
		.vw       (q_rdata[2*VW-1 -: VW]),
		.vs       (q_rdata[VW-1:0]),
		.pop      (pop),
		.empty    (empty),
		.quat_w   (quat_w),
		.quat_x   (quat_x),
		.quat_y   (quat_y),
		.quat_z   (quat_z),
		.case_code(b_code_out)
	);

	assign case_code = b_code_out;

endmodule

// ===== rtl/core/rbv_queue.sv =====
module rbv_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) wr |-> !full)
		else $error("request written into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) rd |-> !empty)
		else $error("request read from an empty queue");
`endif

endmodule

// ===== rtl/core/rbv_isqrt.sv =====
module rbv_isqrt (
	input  logic                           clk,
	input  logic                           en,
	input  logic [rbv_pkg::ROOT_W-1:0]     x,
	output logic [rbv_pkg::ROOT_W/2-1:0]   root,
	output logic [rbv_pkg::ROOT_W-1:0]     rem
);

	localparam int W = rbv_pkg::ROOT_W;
	localparam int N = rbv_pkg::ROOT_STAGES;

	logic [W-1:0] x_s [1:N];
	logic [W-1:0] r_s [1:N];

	// one result bit per stage, digit-by-digit restoring root
	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
		logic [W-1:0] cx;
		logic [W-1:0] cr;
		logic [W-1:0] trial;

		if (k == 0) begin : g_first
			assign cx = x;
			assign cr = '0;
		end else begin : g_next
			assign cx = x_s[k];
			assign cr = r_s[k];
		end

		assign trial = cr + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (cx >= trial) begin
					x_s[k+1] <= cx - trial;
					r_s[k+1] <= (cr >> 1) + BIT;
				end else begin
					x_s[k+1] <= cx;
					r_s[k+1] <= cr >> 1;
				end
			end
		end
	end

	assign root = r_s[N][W/2-1:0];
	assign rem  = x_s[N];

endmodule

// ===== rtl/core/rbv_div.sv =====
module rbv_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32,
	parameter int QW    = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QW-1:0]    quo
);

	localparam int DXW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

	logic [DXW-1:0]   r_s [1:QW];
	logic [DEN_W-1:0] d_s [1:QW];
	logic [QW-1:0]    q_s [1:QW];

	// restoring division, one quotient bit per stage, msb first
	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int BITPOS = QW - 1 - k;
		logic [DXW-1:0]   cr;
		logic [DEN_W-1:0] cd;
		logic [QW-1:0]    cq;
		logic [DXW-1:0]   sh;

		if (k == 0) begin : g_first
			assign cr = DXW'(num);
			assign cd = den;
			assign cq = '0;
		end else begin : g_next
			assign cr = r_s[k];
			assign cd = d_s[k];
			assign cq = q_s[k];
		end

		assign sh = DXW'(cd) << BITPOS;

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1] <= cd;
				if (cr >= sh) begin
					r_s[k+1] <= cr - sh;
					q_s[k+1] <= cq | (QW'(1) << BITPOS);
				end else begin
					r_s[k+1] <= cr;
					q_s[k+1] <= cq;
				end
			end
		end
	end

	assign quo = q_s[QW];

endmodule

// ===== rtl/core/rbv_front.sv =====
module rbv_front #(
	parameter int DW = 16,
	parameter int FB = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic signed [DW-1:0]             from_x,
	input  logic signed [DW-1:0]             from_y,
	input  logic signed [DW-1:0]             from_z,
	input  logic signed [DW-1:0]             to_x,
	input  logic signed [DW-1:0]             to_y,
	input  logic signed [DW-1:0]             to_z,
	input  logic [rbv_pkg::EPS_W-1:0]        eps,
	input  logic                             q_full,
	output logic                             wr,
	output rbv_pkg::case_code_t              code,
	output logic signed [2*DW:0]             axis_x,
	output logic signed [2*DW:0]             axis_y,
	output logic signed [2*DW:0]             axis_z,
	output logic [FB+1:0]                    vw,
	output logic [FB+1:0]                    vs
);

	localparam int EW   = rbv_pkg::EPS_W;
	localparam int AW   = 2 * DW + 1;
	localparam int PW   = 2 * DW;
	localparam int SUMW = 2 * DW + 2;
	localparam int CX   = ((2 * DW + 3 > FB + 3) ? 2 * DW + 3 : FB + 3) + 1;
	localparam int VW   = FB + 2;
	localparam int E2W  = 2 * EW;
	localparam int L2W  = (2 * DW + 1 > E2W) ? 2 * DW + 1 : E2W;

	localparam logic signed [CX-1:0] ONE_C = CX'(64'd1 << FB);
	localparam logic signed [CX-1:0] TWO_C = CX'(64'd2 << FB);

	logic en;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [DW-1:0] f_s1 [3];
	logic signed [DW-1:0] t_s1 [3];
	logic signed [DW-1:0] f_s2 [3];
	logic signed [PW-1:0] dp_s2 [3];
	logic signed [PW-1:0] cp_s2 [6];
	logic signed [PW-1:0] sq_s2 [2];
	logic signed [DW-1:0] f_s3 [3];
	logic signed [SUMW-1:0] sum_s3;
	logic signed [AW-1:0] cross_s3 [3];
	logic [L2W-1:0]       len2_s3;
	logic [E2W-1:0]       eps2_s3;

	rbv_pkg::case_code_t  code_s4;
	logic signed [AW-1:0] axis_s4 [3];
	logic [VW-1:0]        vw_s4, vs_s4;

	rbv_pkg::case_code_t  code_c;
	logic signed [AW-1:0] axis_c [3];
	logic signed [CX-1:0] c_c;
	logic signed [CX-1:0] eps_x;

	function automatic logic [VW-1:0] clamp_arg(input logic signed [CX-1:0] v);
		if (v[CX-1]) begin
			return '0;
		end else if (v > TWO_C) begin
			return VW'(TWO_C);
		end else begin
			return VW'(v);
		end
	endfunction

	assign en   = !(v_s4 && q_full);
	assign full = !en;
	assign wr   = v_s4 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1[0] <= from_x;
			f_s1[1] <= from_y;
			f_s1[2] <= from_z;
			t_s1[0] <= to_x;
			t_s1[1] <= to_y;
			t_s1[2] <= to_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s2 <= f_s1;
			for (int i = 0; i < 3; i++) begin
				dp_s2[i] <= PW'(f_s1[i]) * PW'(t_s1[i]);
			end
			cp_s2[0] <= PW'(f_s1[1]) * PW'(t_s1[2]);
			cp_s2[1] <= PW'(f_s1[2]) * PW'(t_s1[1]);
			cp_s2[2] <= PW'(f_s1[2]) * PW'(t_s1[0]);
			cp_s2[3] <= PW'(f_s1[0]) * PW'(t_s1[2]);
			cp_s2[4] <= PW'(f_s1[0]) * PW'(t_s1[1]);
			cp_s2[5] <= PW'(f_s1[1]) * PW'(t_s1[0]);
			sq_s2[0] <= PW'(f_s1[0]) * PW'(f_s1[0]);
			sq_s2[1] <= PW'(f_s1[1]) * PW'(f_s1[1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s3        <= f_s2;
			sum_s3      <= SUMW'(dp_s2[0]) + SUMW'(dp_s2[1]) + SUMW'(dp_s2[2]);
			cross_s3[0] <= AW'(cp_s2[0]) - AW'(cp_s2[1]);
			cross_s3[1] <= AW'(cp_s2[2]) - AW'(cp_s2[3]);
			cross_s3[2] <= AW'(cp_s2[4]) - AW'(cp_s2[5]);
			len2_s3     <= L2W'($unsigned(sq_s2[0])) + L2W'($unsigned(sq_s2[1]));
			eps2_s3     <= E2W'(eps) * E2W'(eps);
		end
	end

	// arithmetic shift is the floor of the exact dot product
	assign c_c   = CX'(sum_s3 >>> FB);
	assign eps_x = $signed({{(CX - EW){1'b0}}, eps});

	always_comb begin
		axis_c = cross_s3;
		if (c_c > ONE_C - eps_x) begin
			code_c = rbv_pkg::CODE_IDENTITY;
		end else if (c_c < eps_x - ONE_C) begin
			code_c = rbv_pkg::CODE_OPPOSITE;
			if (len2_s3 < L2W'(eps2_s3)) begin
				// z cross from is too short: use x cross from
				axis_c[0] = '0;
				axis_c[1] = -AW'(f_s3[2]);
				axis_c[2] = AW'(f_s3[1]);
			end else begin
				axis_c[0] = -AW'(f_s3[1]);
				axis_c[1] = AW'(f_s3[0]);
				axis_c[2] = '0;
			end
		end else begin
			code_c = rbv_pkg::CODE_GENERAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s4 <= code_c;
			axis_s4 <= axis_c;
			vw_s4   <= clamp_arg(ONE_C + c_c);
			vs_s4   <= clamp_arg(ONE_C - c_c);
		end
	end

	assign code   = code_s4;
	assign axis_x = axis_s4[0];
	assign axis_y = axis_s4[1];
	assign axis_z = axis_s4[2];
	assign vw     = vw_s4;
	assign vs     = vs_s4;

endmodule

// ===== rtl/core/rbv_back.sv =====
module rbv_back #(
	parameter int DW = 16,
	parameter int FB = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	output logic                  q_rd,
	input  rbv_pkg::case_code_t   code,
	input  logic signed [2*DW:0]  axis_x,
	input  logic signed [2*DW:0]  axis_y,
	input  logic signed [2*DW:0]  axis_z,
	input  logic [FB+1:0]         vw,
	input  logic [FB+1:0]         vs,
	input  logic                  pop,
	output logic                  empty,
	output logic signed [DW-1:0]  quat_w,
	output logic signed [DW-1:0]  quat_x,
	output logic signed [DW-1:0]  quat_y,
	output logic signed [DW-1:0]  quat_z,
	output rbv_pkg::case_code_t   case_code
);

	localparam int NW   = rbv_pkg::NORM_W;
	localparam int RW   = rbv_pkg::ROOT_W;
	localparam int RS   = rbv_pkg::ROOT_STAGES;
	localparam int LW   = rbv_pkg::LEN_W;
	localparam int AW   = 2 * DW + 1;
	localparam int MW   = 2 * DW;
	localparam int PIW  = $clog2(MW);
	localparam int VW   = FB + 2;
	localparam int WW   = FB + 2;
	localparam int PRW  = NW + WW;
	localparam int DVW  = PRW + 1;
	localparam int QW   = FB + 3;
	localparam int XW   = ((QW > DW) ? QW : DW) + 2;

	localparam logic [WW-1:0] ONE_W = WW'(64'd1 << FB);
	localparam logic signed [XW-1:0] SAT_HI = XW'((64'd1 << (DW - 1)) - 64'd1);
	localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		rbv_pkg::case_code_t   code;
		logic [2:0]            neg;
		logic                  zero;
		logic [2:0][NW-1:0]    un;
	} rt_pl_t;

	typedef struct packed {
		rbv_pkg::case_code_t   code;
		logic [2:0]            neg;
		logic                  zero;
		logic [WW-1:0]         w;
	} dv_pl_t;

	logic ben;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	rbv_pkg::case_code_t  code_s1, code_s2, code_s3, code_s4, code_s5, code_s6;
	logic [2:0]           neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [2:0][MW-1:0]   u_s1, u_s2, u_s3;
	logic [VW-1:0]        vw_s1, vw_s2, vw_s3, vw_s4, vw_s5;
	logic [VW-1:0]        vs_s1, vs_s2, vs_s3, vs_s4, vs_s5;
	logic [MW-1:0]        m_s2;
	logic [PIW-1:0]       p_s3;
	logic                 zero_s3, zero_s4, zero_s5, zero_s6;
	logic [2:0][NW-1:0]   un_s4, un_s5, un_s6;
	logic [2*NW-1:0]      sq_s5 [3];
	logic [RW-1:0]        sum_s6, xw_s6, xs_s6;

	logic [RS-1:0]        rt_v_q;
	rt_pl_t               rt_pl_q [RS];
	rt_pl_t               pl6;

	logic [RW/2-1:0]      root_l, root_w, root_s;
	logic [RW-1:0]        rem_w, rem_s;

	rbv_pkg::case_code_t  code_s7, code_s8;
	logic [2:0]           neg_s7, neg_s8;
	logic                 zero_s7, zero_s8;
	logic [2:0][NW-1:0]   un_s7;
	logic [WW-1:0]        w_s7, w_s8, s_s7;
	logic [LW-1:0]        len_s7, len_s8;
	logic [PRW-1:0]       prod_s8 [3];

	logic [QW-1:0]        quo [3];
	logic [QW-1:0]        dv_v_q;
	dv_pl_t               dv_pl_q [QW];
	dv_pl_t               pl8;
	dv_pl_t               pl_last;

	logic                 ov_q;
	logic signed [DW-1:0] qw_q, qx_q, qy_q, qz_q;
	rbv_pkg::case_code_t  code_q;
	logic signed [DW-1:0] qv_c [3];

	function automatic logic signed [DW-1:0] sat(input logic signed [XW-1:0] v);
		if (v > SAT_HI) begin
			return SAT_HI[DW-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[DW-1:0];
		end else begin
			return v[DW-1:0];
		end
	endfunction

	// whole back end holds while a result waits unpopped
	assign ben  = !ov_q || pop;
	assign q_rd = ben && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			rt_v_q <= '0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			dv_v_q <= '0;
			ov_q   <= 1'b0;
		end else if (ben) begin
			v_s1   <= !q_empty;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			rt_v_q <= {rt_v_q[RS-2:0], v_s6};
			v_s7   <= rt_v_q[RS-1];
			v_s8   <= v_s7;
			dv_v_q <= {dv_v_q[QW-2:0], v_s8};
			ov_q   <= dv_v_q[QW-1];
		end
	end

	// magnitudes
	always_ff @(posedge clk) begin
		if (ben) begin
			code_s1   <= code;
			neg_s1[0] <= axis_x[AW-1];
			neg_s1[1] <= axis_y[AW-1];
			neg_s1[2] <= axis_z[AW-1];
			u_s1[0]   <= axis_x[AW-1] ? MW'(-axis_x) : MW'(axis_x);
			u_s1[1]   <= axis_y[AW-1] ? MW'(-axis_y) : MW'(axis_y);
			u_s1[2]   <= axis_z[AW-1] ? MW'(-axis_z) : MW'(axis_z);
			vw_s1     <= vw;
			vs_s1     <= vs;
		end
	end

	// largest magnitude
	always_ff @(posedge clk) begin
		if (ben) begin
			code_s2 <= code_s1;
			neg_s2  <= neg_s1;
			u_s2    <= u_s1;
			vw_s2   <= vw_s1;
			vs_s2   <= vs_s1;
			if (u_s1[0] >= u_s1[1] && u_s1[0] >= u_s1[2]) begin
				m_s2 <= u_s1[0];
			end else if (u_s1[1] >= u_s1[2]) begin
				m_s2 <= u_s1[1];
			end else begin
				m_s2 <= u_s1[2];
			end
		end
	end

	// leading one position
	always_ff @(posedge clk) begin
		if (ben) begin
			code_s3 <= code_s2;
			neg_s3  <= neg_s2;
			u_s3    <= u_s2;
			vw_s3   <= vw_s2;
			vs_s3   <= vs_s2;
			zero_s3 <= (m_s2 == '0);
			p_s3    <= '0;
			for (int j = 0; j < MW; j++) begin
				if (m_s2[j]) begin
					p_s3 <= PIW'(j);
				end
			end
		end
	end

	// put the leading one of the largest part at bit 30, truncating
	always_ff @(posedge clk) begin
		if (ben) begin
			code_s4 <= code_s3;
			neg_s4  <= neg_s3;
			vw_s4   <= vw_s3;
			vs_s4   <= vs_s3;
			zero_s4 <= zero_s3;
			for (int i = 0; i < 3; i++) begin
				un_s4[i] <= NW'({u_s3[i], {NW{1'b0}}} >> ((PIW+1)'(p_s3) + (PIW+1)'(1)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			code_s5 <= code_s4;
			neg_s5  <= neg_s4;
			vw_s5   <= vw_s4;
			vs_s5   <= vs_s4;
			zero_s5 <= zero_s4;
			un_s5   <= un_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= (2*NW)'(un_s4[i]) * (2*NW)'(un_s4[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			code_s6 <= code_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
			un_s6   <= un_s5;
			sum_s6  <= RW'(sq_s5[0]) + RW'(sq_s5[1]) + RW'(sq_s5[2]);
			xw_s6   <= RW'(vw_s5) << (FB - 1);
			xs_s6   <= RW'(vs_s5) << (FB - 1);
		end
	end

	rbv_isqrt u_root_len (.clk(clk), .en(ben), .x(sum_s6), .root(root_l), .rem());
	rbv_isqrt u_root_w   (.clk(clk), .en(ben), .x(xw_s6),  .root(root_w), .rem(rem_w));
	rbv_isqrt u_root_s   (.clk(clk), .en(ben), .x(xs_s6),  .root(root_s), .rem(rem_s));

	assign pl6 = '{code: code_s6, neg: neg_s6, zero: zero_s6, un: un_s6};

	always_ff @(posedge clk) begin
		if (ben) begin
			rt_pl_q[0] <= pl6;
			for (int k = 1; k < RS; k++) begin
				rt_pl_q[k] <= rt_pl_q[k-1];
			end
		end
	end

	// round to nearest, then pick scalar and scale per case
	always_ff @(posedge clk) begin
		if (ben) begin
			code_s7 <= rt_pl_q[RS-1].code;
			neg_s7  <= rt_pl_q[RS-1].neg;
			zero_s7 <= rt_pl_q[RS-1].zero;
			un_s7   <= rt_pl_q[RS-1].un;
			len_s7  <= LW'(root_l);
			case (rt_pl_q[RS-1].code)
				rbv_pkg::CODE_IDENTITY: begin
					// identity has no vector part
					w_s7 <= ONE_W;
					s_s7 <= '0;
				end
				rbv_pkg::CODE_OPPOSITE: begin
					w_s7 <= '0;
					s_s7 <= ONE_W;
				end
				default: begin
					w_s7 <= WW'(root_w) + WW'(rem_w > RW'(root_w));
					s_s7 <= WW'(root_s) + WW'(rem_s > RW'(root_s));
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			code_s8 <= code_s7;
			neg_s8  <= neg_s7;
			zero_s8 <= zero_s7;
			w_s8    <= w_s7;
			len_s8  <= len_s7;
			for (int i = 0; i < 3; i++) begin
				prod_s8[i] <= PRW'(un_s7[i]) * PRW'(s_s7);
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		rbv_div #(
			.NUM_W(DVW),
			.DEN_W(LW),
			.QW   (QW)
		) u_div (
			.clk(clk),
			.en (ben),
			.num(DVW'(prod_s8[i]) + DVW'(len_s8 >> 1)),
			.den(len_s8),
			.quo(quo[i])
		);
	end

	assign pl8 = '{code: code_s8, neg: neg_s8, zero: zero_s8, w: w_s8};

	always_ff @(posedge clk) begin
		if (ben) begin
			dv_pl_q[0] <= pl8;
			for (int k = 1; k < QW; k++) begin
				dv_pl_q[k] <= dv_pl_q[k-1];
			end
		end
	end

	assign pl_last = dv_pl_q[QW-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pl_last.zero) begin
				qv_c[i] = '0;
			end else if (pl_last.neg[i]) begin
				qv_c[i] = sat(-$signed({{(XW - QW){1'b0}}, quo[i]}));
			end else begin
				qv_c[i] = sat($signed({{(XW - QW){1'b0}}, quo[i]}));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			qw_q   <= sat($signed({{(XW - WW){1'b0}}, pl_last.w}));
			qx_q   <= qv_c[0];
			qy_q   <= qv_c[1];
			qz_q   <= qv_c[2];
			code_q <= pl_last.code;
		end
	end

	assign empty     = !ov_q;
	assign quat_w    = qw_q;
	assign quat_x    = qx_q;
	assign quat_y    = qy_q;
	assign quat_z    = qz_q;
	assign case_code = code_q;

`ifndef SYNTHESIS
	a_identity_no_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && code_q == rbv_pkg::CODE_IDENTITY) |-> (qx_q == '0 && qy_q == '0 && qz_q == '0))
		else $error("identity result with nonzero vector part");
	a_half_turn_w: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && code_q == rbv_pkg::CODE_OPPOSITE) |-> (qw_q == '0))
		else $error("half-turn result with nonzero scalar part");
`endif

endmodule
